/* rtl/ltc_pkg.sv */
// shared types, constants and keyword table for the lexical token classifier
`default_nettype none

package ltc_pkg;

  // longest pending token the length count follows
  localparam int MAX_TOKEN_LEN = 255;
  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  // token records held between the classifier and the result sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int NUM_KW = 11;
  localparam int KW_MAXLEN = 8;

  // right-justified keyword text, first character in the highest used byte
  localparam logic [8*KW_MAXLEN-1:0] KW_WORD [NUM_KW] = '{
    64'("goku"), 64'("vegeta"), 64'("gohan"), 64'("trunks"),
    64'("bulma"), 64'("chichi"), 64'("goten"), 64'("piccalo"),
    64'("krillen"), 64'("kami"), 64'("popo")
  };
  localparam int KW_LEN [NUM_KW] = '{4, 6, 5, 6, 5, 6, 5, 7, 7, 4, 4};

  // character codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    KIND_KEYWORD  = 3'd0,
    KIND_INTEGER  = 3'd1,
    KIND_REAL     = 3'd2,
    KIND_IDENT    = 3'd3,
    KIND_BAD_ID   = 3'd4,
    KIND_OPERATOR = 3'd5
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic [7:0]  operator_code;
    logic        last_of_run;
  } out_word_t;

  // everything one input byte produces: an optional token and an optional operator
  typedef struct packed {
    logic        has_tok;
    tok_kind_t   tok_kind;
    logic [15:0] tok_start;
    logic [7:0]  tok_length;
    logic        has_op;
    logic [15:0] op_start;
    logic [7:0]  op_code;
  } tok_rec_t;

  // character of keyword k at position pos, zero past its end
  function automatic logic [7:0] kw_byte(input int k, input logic [2:0] pos);
    int sh;
    sh = 8 * (KW_LEN[k] - 1 - int'(pos));
    if (sh < 0) begin
      return 8'h00;
    end
    return 8'(KW_WORD[k] >> sh);
  endfunction

endpackage

`default_nettype wire

/* rtl/ltc_front.sv */
// byte intake: token state, delimiter detection and classification
`default_nettype none

module ltc_front import ltc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_word_t in_word,
  output logic          in_stall,
  input  wire logic     q_full,
  output logic          rec_push,
  output tok_rec_t      rec
);

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [15:0]       start_r, start_nxt;
  logic [15:0]       pos_r, pos_nxt;
  logic              first_dig_r, first_dig_nxt;
  logic              only_dig_r, only_dig_nxt;
  logic              only_dd_r, only_dd_nxt;
  logic              seen_dot_r, seen_dot_nxt;
  logic [NUM_KW-1:0] alive_r, alive_nxt;

  logic              accept;
  logic [7:0]        c;
  logic              eot, digit, is_dot, is_op, is_delim;

  // state as it would be after appending this byte
  logic [LEN_W-1:0]  a_len;
  logic [15:0]       a_start;
  logic              a_first, a_only_dig, a_only_dd, a_seen;
  logic [NUM_KW-1:0] a_alive;

  logic [LEN_W-1:0]  cls_len;
  tok_kind_t         cls_kind;

  function automatic tok_kind_t classify(input logic [NUM_KW-1:0] alive,
                                         input logic [LEN_W-1:0] len,
                                         input logic only_dig, input logic only_dd,
                                         input logic seen, input logic first);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (alive[k] && (32'(len) == KW_LEN[k])) hit = 1'b1;
    end
    if (hit) return KIND_KEYWORD;
    if (only_dig) return KIND_INTEGER;
    if (only_dd && seen) return KIND_REAL;
    return first ? KIND_BAD_ID : KIND_IDENT;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c        = in_word.char_code;
  assign eot      = in_word.end_of_text;

  always_comb begin
    digit    = (c inside {[CH_ZERO:CH_NINE]});
    is_dot   = (c == CH_DOT);
    is_op    = (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_GT, CH_LT, CH_EQ});
    is_delim = is_op || (c inside {CH_SPACE, CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN,
                                   CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE});
  end

  always_comb begin
    a_len      = (32'(len_r) < MAX_TOKEN_LEN) ? len_r + 1'b1 : len_r;
    a_start    = (len_r == '0) ? pos_r : start_r;
    a_first    = (len_r == '0) ? digit : first_dig_r;
    a_only_dig = only_dig_r && digit;
    a_only_dd  = only_dd_r && (digit || is_dot);
    a_seen     = seen_dot_r || is_dot;
    for (int k = 0; k < NUM_KW; k++) begin
      a_alive[k] = alive_r[k] && (32'(len_r) < KW_LEN[k]) &&
                   (kw_byte(k, len_r[2:0]) == c);
    end
  end

  // classify the pending token, or the token just completed by end of text
  always_comb begin
    if (is_delim) begin
      cls_len  = len_r;
      cls_kind = classify(alive_r, len_r, only_dig_r, only_dd_r, seen_dot_r,
                          first_dig_r);
      rec.has_tok   = (len_r != '0);
      rec.tok_start = start_r;
    end else begin
      cls_len  = a_len;
      cls_kind = classify(a_alive, a_len, a_only_dig, a_only_dd, a_seen, a_first);
      rec.has_tok   = eot;
      rec.tok_start = a_start;
    end
    rec.tok_kind   = cls_kind;
    rec.tok_length = (32'(cls_len) > 255) ? 8'hFF : 8'(cls_len);
    rec.has_op     = is_op;
    rec.op_start   = pos_r;
    rec.op_code    = c;
    rec_push       = accept && (rec.has_tok || rec.has_op);
  end

  always_comb begin
    len_nxt       = len_r;
    start_nxt     = start_r;
    pos_nxt       = pos_r;
    first_dig_nxt = first_dig_r;
    only_dig_nxt  = only_dig_r;
    only_dd_nxt   = only_dd_r;
    seen_dot_nxt  = seen_dot_r;
    alive_nxt     = alive_r;
    if (accept) begin
      pos_nxt = pos_r + 16'd1;
      if (eot) begin
        len_nxt       = '0;
        start_nxt     = '0;
        pos_nxt       = '0;
        first_dig_nxt = 1'b0;
        only_dig_nxt  = 1'b1;
        only_dd_nxt   = 1'b1;
        seen_dot_nxt  = 1'b0;
        alive_nxt     = '1;
      end else if (is_delim) begin
        if (len_r != '0) begin
          len_nxt       = '0;
          first_dig_nxt = 1'b0;
          only_dig_nxt  = 1'b1;
          only_dd_nxt   = 1'b1;
          seen_dot_nxt  = 1'b0;
          alive_nxt     = '1;
        end
      end else begin
        len_nxt       = a_len;
        start_nxt     = a_start;
        first_dig_nxt = a_first;
        only_dig_nxt  = a_only_dig;
        only_dd_nxt   = a_only_dd;
        seen_dot_nxt  = a_seen;
        alive_nxt     = a_alive;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      start_r     <= '0;
      pos_r       <= '0;
      first_dig_r <= 1'b0;
      only_dig_r  <= 1'b1;
      only_dd_r   <= 1'b1;
      seen_dot_r  <= 1'b0;
      alive_r     <= '1;
    end else begin
      len_r       <= len_nxt;
      start_r     <= start_nxt;
      pos_r       <= pos_nxt;
      first_dig_r <= first_dig_nxt;
      only_dig_r  <= only_dig_nxt;
      only_dd_r   <= only_dd_nxt;
      seen_dot_r  <= seen_dot_nxt;
      alive_r     <= alive_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ltc_queue.sv */
// small register queue of token records between intake and result sequencer
`default_nettype none

module ltc_queue import ltc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tok_rec_t push_rec,
  input  wire logic     pop,
  output tok_rec_t      head,
  output logic          not_empty,
  output logic          full
);

  tok_rec_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head      = slot_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (32'(cnt_r) == QUEUE_DEPTH);

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

/* rtl/ltc_back.sv */
// result sequencer: turns each record into one or two output words
`default_nettype none

module ltc_back import ltc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tok_rec_t head,
  input  wire logic     head_valid,
  output logic          pop,
  output logic          out_valid,
  output out_word_t     out_word,
  input  wire logic     out_stall
);

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      op_phase_r, op_phase_nxt;
  logic      load, fire;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // output register takes a new word when empty or being drained
  assign load = !out_valid_r || !out_stall;
  assign fire = load && head_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    op_phase_nxt  = op_phase_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
    end
    if (fire) begin
      if (head.has_tok && !op_phase_r) begin
        out_word_nxt.token_kind    = head.tok_kind;
        out_word_nxt.token_start   = head.tok_start;
        out_word_nxt.token_length  = head.tok_length;
        out_word_nxt.operator_code = 8'h00;
        out_word_nxt.last_of_run   = !head.has_op;
        op_phase_nxt               = head.has_op;
        pop                        = !head.has_op;
      end else begin
        out_word_nxt.token_kind    = KIND_OPERATOR;
        out_word_nxt.token_start   = head.op_start;
        out_word_nxt.token_length  = 8'd1;
        out_word_nxt.operator_code = head.op_code;
        out_word_nxt.last_of_run   = 1'b1;
        op_phase_nxt               = 1'b0;
        pop                        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      op_phase_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      op_phase_r  <= op_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

/* rtl/lexical_token_classifier.sv */
// top level of the lexical token classifier
//
// Takes source text one byte per word and emits classified tokens. Space,
// comma, semicolon, brackets and the operators + - * / > < = end the pending
// token, which is reported as keyword, integer, real, valid identifier or
// invalid identifier; an operator byte then gives an operator word of its own.
// A byte with end_of_text set flushes any pending token and restarts the byte
// position at zero. The intake accepts one byte per cycle while the queue is not
// full; classification is combinational. Each record gives one output word, or
// two for a byte that both ends a token and is an operator. A four-record queue
// sits between intake and output, so in_stall rises only when that queue is full,
// and out_valid is driven from the result sequencer's output register.
`default_nettype none

module lexical_token_classifier import ltc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_word_t  in_word,
  output logic           in_stall,
  output logic           out_valid,
  output out_word_t      out_word,
  input  wire logic      out_stall
);

  // intake to queue
  logic     rec_push;
  tok_rec_t rec;
  logic     q_full;

  // queue to sequencer
  tok_rec_t head;
  logic     head_valid;
  logic     pop;

  // byte intake and classification
  ltc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .q_full   (q_full),
    .rec_push (rec_push),
    .rec      (rec)
  );

  // decouples intake from output back-pressure
  ltc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_rec  (rec),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (q_full)
  );

  // splits records into output words, output register included
  ltc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .out_stall  (out_stall)
  );

endmodule

`default_nettype wire

/* test/ltc_checker.sv */
// result checker for the lexical token classifier: predicts each word and compares
`timescale 1ns / 100ps

module ltc_checker import ltc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        mismatches,
  output int        words_waiting,
  output int        words_checked
);

  out_word_t expected_words [$];

  // scanner state of the pending token
  int                tok_len;
  logic [15:0]       tok_start;
  logic [15:0]       byte_pos;
  logic              first_digit;
  logic              all_digits;
  logic              digits_dots;
  logic              dot_seen;
  logic [NUM_KW-1:0] kw_live;

  function automatic string kw_text(input int k);
    case (k)
      0: return "goku";
      1: return "vegeta";
      2: return "gohan";
      3: return "trunks";
      4: return "bulma";
      5: return "chichi";
      6: return "goten";
      7: return "piccalo";
      8: return "krillen";
      9: return "kami";
      10: return "popo";
      default: return "";
    endcase
  endfunction

  function automatic logic is_operator_byte(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_GT || c == CH_LT || c == CH_EQ;
  endfunction

  function automatic logic is_delimiter_byte(input logic [7:0] c);
    return is_operator_byte(c) || c == CH_SPACE || c == CH_COMMA || c == CH_SEMI ||
           c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_LBRACE || c == CH_RBRACE;
  endfunction

  task automatic clear_token();
    tok_len = 0;
    first_digit = 1'b0;
    all_digits = 1'b1;
    digits_dots = 1'b1;
    dot_seen = 1'b0;
    kw_live = '1;
  endtask

  // lowest priority first, so later matches win
  function automatic out_word_t token_word();
    string     kw;
    out_word_t w;
    tok_kind_t kind;
    kind = first_digit ? KIND_BAD_ID : KIND_IDENT;
    if (digits_dots && dot_seen) kind = KIND_REAL;
    if (all_digits) kind = KIND_INTEGER;
    for (int k = 0; k < NUM_KW; k++) begin
      kw = kw_text(k);
      if (kw_live[k] && kw.len() == tok_len) kind = KIND_KEYWORD;
    end
    w = '0;
    w.token_kind = kind;
    w.token_start = tok_start;
    w.token_length = (tok_len > 255) ? 8'd255 : 8'(tok_len);
    return w;
  endfunction

  task automatic classify_byte(input in_word_t w);
    logic [7:0] c;
    logic       eot;
    logic       digit;
    string      kw;
    out_word_t  made [2];
    int         n;
    c = w.char_code;
    eot = w.end_of_text;
    n = 0;
    if (is_delimiter_byte(c)) begin
      if (tok_len != 0) begin
        made[n] = token_word();
        n++;
        clear_token();
      end
      if (is_operator_byte(c)) begin
        made[n] = '0;
        made[n].token_kind = KIND_OPERATOR;
        made[n].token_start = byte_pos;
        made[n].token_length = 8'd1;
        made[n].operator_code = c;
        n++;
      end
    end else begin
      digit = (c >= CH_ZERO && c <= CH_NINE);
      if (tok_len == 0) begin
        tok_start = byte_pos;
        first_digit = digit;
      end
      for (int k = 0; k < NUM_KW; k++) begin
        kw = kw_text(k);
        if (tok_len >= kw.len() || kw[tok_len] != c) kw_live[k] = 1'b0;
      end
      if (!digit) all_digits = 1'b0;
      if (!digit && c != CH_DOT) digits_dots = 1'b0;
      if (c == CH_DOT) dot_seen = 1'b1;
      if (tok_len < MAX_TOKEN_LEN) tok_len++;
      if (eot) begin
        made[n] = token_word();
        n++;
        clear_token();
      end
    end
    byte_pos = byte_pos + 16'd1;
    // end of text restarts positions for the next text
    if (eot) begin
      tok_start = '0;
      byte_pos = '0;
      clear_token();
    end
    if (n > 0) made[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_words.push_back(made[i]);
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    logic      bad;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: kind %0d start %0d len %0d op %h last %0d",
                 got.token_kind, got.token_start, got.token_length, got.operator_code,
                 got.last_of_run);
    end else begin
      want = expected_words.pop_front();
      words_checked++;
      bad = (got.token_kind !== want.token_kind) || (got.token_start !== want.token_start) ||
            (got.token_length !== want.token_length) ||
            (got.operator_code !== want.operator_code) ||
            (got.last_of_run !== want.last_of_run);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d expected: kind %0d start %0d len %0d op %h last %0d",
                   words_checked, want.token_kind, want.token_start, want.token_length,
                   want.operator_code, want.last_of_run);
          $display("result %0d actual:   kind %0d start %0d len %0d op %h last %0d",
                   words_checked, got.token_kind, got.token_start, got.token_length,
                   got.operator_code, got.last_of_run);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_words.delete();
      tok_start = '0;
      byte_pos = '0;
      clear_token();
      mismatches = 0;
      words_checked = 0;
    end else begin
      if (in_valid && !in_stall) classify_byte(in_word);
      if (out_valid && !out_stall) check_word(out_word);
    end
    words_waiting = expected_words.size();
  end

endmodule

/* test/testbench.sv */
// top of the lexical token classifier testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import ltc_pkg::*;

  // generous bound for the whole run
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PHASE_BYTES  = 215;

  // every byte that ends a token
  localparam logic [7:0] DELIMS [16] = '{
    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_GT, CH_LT, CH_EQ, CH_SPACE,
    CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  in_word_t  in_word;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;
  logic      out_stall;

  int mismatches;
  int words_waiting;
  int words_checked;

  // knobs and state of the sender, the receiver and the watchdog
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  logic in_took = 1'b0;

  lexical_token_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

  ltc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .mismatches    (mismatches),
    .words_waiting (words_waiting),
    .words_checked (words_checked)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // acceptance as seen at the edge, read back by the sender at the next falling edge
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycle_count,
               words_waiting);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // receiver: a long hold-off when asked, otherwise random stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // keyword character i from the package table
  function automatic logic [7:0] kw_char(input int k, input int i);
    return 8'(KW_WORD[k] >> (8 * (KW_LEN[k] - 1 - i)));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(CH_ZERO, CH_NINE));
  endfunction

  // lowercase letter
  function automatic logic [7:0] rand_lower();
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // letters, digits, dot or underscore
  function automatic logic [7:0] rand_ident_char();
    case ($urandom_range(0, 3))
      0: return rand_lower();
      1: return 8'($urandom_range(8'h41, 8'h5A));
      2: return rand_digit();
      default: return $urandom_range(0, 1) ? CH_DOT : 8'h5F;
    endcase
  endfunction

  // offer one word, with random idle cycles ahead of it, and wait for the handshake
  task automatic send_byte(input logic [7:0] c, input logic eot);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= {c, eot};
    do @(negedge clk); while (!in_took);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // one token of a random class followed by one to three delimiters
  task automatic send_token();
    int         cls;
    int         k;
    int         len;
    int         spot;
    logic       eot_last;
    logic [7:0] c;
    cls = $urandom_range(0, 9);
    k = $urandom_range(0, NUM_KW - 1);
    case (cls)
      0, 1: len = KW_LEN[k];
      2: len = KW_LEN[k] + $urandom_range(0, 2) - 1;
      8: len = $urandom_range(1, 6);
      default: len = $urandom_range(1, 10);
    endcase
    spot = $urandom_range(0, len - 1);
    eot_last = ($urandom_range(0, 19) == 0);
    for (int i = 0; i < len; i++) begin
      case (cls)
        0, 1: c = kw_char(k, i);
        2: begin
          // near miss: one byte short, one byte too many, or one byte changed
          if (i >= KW_LEN[k]) c = rand_lower();
          else if (len == KW_LEN[k] && i == spot) c = kw_char(k, i) ^ 8'h01;
          else c = kw_char(k, i);
        end
        3: c = rand_digit();
        4: c = (i == spot || $urandom_range(0, 3) == 0) ? CH_DOT : rand_digit();
        5, 6: c = (i == 0) ? rand_lower() : rand_ident_char();
        7: c = (i == 0) ? rand_digit() : (i == 1) ? rand_lower() : rand_ident_char();
        8: c = 8'($urandom_range(0, 255));
        default: c = $urandom_range(0, 1) ? CH_DOT : rand_digit();
      endcase
      send_byte(c, eot_last && i == len - 1);
    end
    repeat ($urandom_range(1, 3)) send_byte(DELIMS[$urandom_range(0, 15)],
                                            $urandom_range(0, 39) == 0);
  endtask

  // token at or past the length count's ceiling, digits or letters, then a space
  task automatic send_long_token(input int len, input logic digits);
    for (int i = 0; i < len; i++) send_byte(digits ? rand_digit() : rand_lower(), 1'b0);
    send_byte(CH_SPACE, 1'b0);
  endtask

  // sender holds back until every predicted word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_waiting != 0) @(negedge clk);
  endtask

  initial begin
    int mark;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: each kind, every operator, operator with nothing pending
    send_text("goku+12-3.5*x9/9x><=");
    // zero byte is an ordinary character
    send_byte(8'h00, 1'b0);
    send_byte(CH_COMMA, 1'b0);
    // top byte value flushed by end of text
    send_byte(8'hFF, 1'b1);
    // end of text on a delimiter
    send_byte(8'h61, 1'b0);
    send_byte(CH_SPACE, 1'b1);

    // receiver holds off while the sender keeps offering, so intake backs up
    hold_left = 150;
    mark = bytes_sent;
    while (bytes_sent - mark < 80) send_token();
    wait_drained();

    // saturating length, exactly at the ceiling and beyond it
    send_long_token(MAX_TOKEN_LEN, 1'b1);
    send_long_token($urandom_range(MAX_TOKEN_LEN + 1, MAX_TOKEN_LEN + 45), 1'b0);
    wait_drained();

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      mark = bytes_sent;
      while (bytes_sent - mark < PHASE_BYTES) begin
        if ($urandom_range(0, 7) == 0)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        else
          send_token();
      end
      wait_drained();
    end

    // let any late stray word show up before the verdict
    stall_pct = 0;
    repeat (20) @(negedge clk);

    $display("covered %0d bytes and %0d result words: all token kinds, operators,",
             bytes_sent, words_checked);
    $display("keyword near misses, zero/high bytes, text ends and length saturation");
    if (mismatches == 0 && words_waiting == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ltc_pkg.sv
rtl/ltc_front.sv
rtl/ltc_queue.sv
rtl/ltc_back.sv
rtl/lexical_token_classifier.sv
test/ltc_checker.sv
test/testbench.sv
